/* hdl/three_axis_rate_pid_unit_defines.svh */
// Assertion macros for the three-axis rate PID unit.
`ifndef THREE_AXIS_RATE_PID_UNIT_DEFINES_SVH
`define THREE_AXIS_RATE_PID_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define TARP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tarp check failed");
// Implication in the next cycle.
`define TARP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tarp check failed");
`else
`define TARP_ASSERT_NOW(name, ante, cons)
`define TARP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hdl/tarp_pkg.sv */
package tarp_pkg;

    localparam int DivBits = 50;
    localparam logic [1:0] AxisYaw = 2'd2;

    // register indexes
    localparam logic [2:0] RegKpRp    = 3'd0;
    localparam logic [2:0] RegKiRp    = 3'd1;
    localparam logic [2:0] RegKdRp    = 3'd2;
    localparam logic [2:0] RegKpYaw   = 3'd3;
    localparam logic [2:0] RegKiYaw   = 3'd4;
    localparam logic [2:0] RegKdYaw   = 3'd5;
    localparam logic [2:0] RegYawScl  = 3'd6;
    localparam logic [2:0] RegIntLim  = 3'd7;

    typedef struct packed {
        logic signed [15:0] stick_roll;
        logic signed [15:0] stick_pitch;
        logic signed [15:0] stick_yaw;
        logic [14:0]        stick_throttle;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [19:0]        time_step;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] roll_drive;
        logic signed [31:0] pitch_drive;
        logic signed [31:0] yaw_drive;
        logic [14:0]        throttle_out;
    } out_req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TGT, ST_ERR, ST_INC, ST_PMUL, ST_DMUL, ST_IMUL,
        ST_ILAT, ST_DIV, ST_SUM, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_TGT, OP_ERR, OP_INC, OP_PMUL, OP_DMUL,
        OP_IMUL, OP_ILAT, OP_SUM, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

/* hdl/tarp_ctrl.sv */
module tarp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tarp_pkg::status_t status,
    output tarp_pkg::cmd_t    cmd,
    output tarp_pkg::state_t  state
);

    tarp_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            tarp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tarp_pkg::ST_TGT;
                    axis_next  = 2'd0;
                end
            end
            tarp_pkg::ST_TGT:  state_next = tarp_pkg::ST_ERR;
            tarp_pkg::ST_ERR:  state_next = tarp_pkg::ST_INC;
            tarp_pkg::ST_INC:  state_next = tarp_pkg::ST_PMUL;
            tarp_pkg::ST_PMUL: state_next = tarp_pkg::ST_DMUL;
            tarp_pkg::ST_DMUL: state_next = tarp_pkg::ST_IMUL;
            tarp_pkg::ST_IMUL: state_next = tarp_pkg::ST_ILAT;
            tarp_pkg::ST_ILAT: state_next = tarp_pkg::ST_DIV;
            tarp_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = tarp_pkg::ST_SUM;
            end
            tarp_pkg::ST_SUM:
            begin
                if (axis_reg == tarp_pkg::AxisYaw)
                    state_next = tarp_pkg::ST_DONE;
                else
                begin
                    state_next = tarp_pkg::ST_TGT;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            tarp_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = tarp_pkg::ST_IDLE;
            end
            default: state_next = tarp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.axis = axis_reg;
        unique case (state_reg)
            tarp_pkg::ST_IDLE: cmd.op = in_valid ? tarp_pkg::OP_LOAD : tarp_pkg::OP_NONE;
            tarp_pkg::ST_TGT:  cmd.op = tarp_pkg::OP_TGT;
            tarp_pkg::ST_ERR:  cmd.op = tarp_pkg::OP_ERR;
            tarp_pkg::ST_INC:  cmd.op = tarp_pkg::OP_INC;
            tarp_pkg::ST_PMUL: cmd.op = tarp_pkg::OP_PMUL;
            tarp_pkg::ST_DMUL: cmd.op = tarp_pkg::OP_DMUL;
            tarp_pkg::ST_IMUL: cmd.op = tarp_pkg::OP_IMUL;
            tarp_pkg::ST_ILAT: cmd.op = tarp_pkg::OP_ILAT;
            tarp_pkg::ST_DIV:  cmd.op = tarp_pkg::OP_NONE;
            tarp_pkg::ST_SUM:  cmd.op = tarp_pkg::OP_SUM;
            tarp_pkg::ST_DONE: cmd.op = slot_free ? tarp_pkg::OP_OUT : tarp_pkg::OP_NONE;
            default:           cmd.op = tarp_pkg::OP_NONE;
        endcase
    end

    // output request valid
    always_comb
    begin
        if (state_reg == tarp_pkg::ST_DONE && slot_free)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tarp_pkg::ST_IDLE;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != tarp_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

/* hdl/tarp_dp.sv */
module tarp_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  tarp_pkg::in_req_t  in_req,
    input  tarp_pkg::cmd_t     cmd,
    output tarp_pkg::status_t  status,
    output tarp_pkg::out_req_t out_req
);

    // configuration
    logic [15:0] kp_rp_reg, ki_rp_reg, kd_rp_reg;
    logic [15:0] kp_yaw_reg, ki_yaw_reg, kd_yaw_reg, yaw_scl_reg;
    logic [22:0] int_lim_reg;

    tarp_pkg::in_req_t in_reg;
    tarp_pkg::out_req_t out_reg;

    logic signed [23:0] integ_reg [3];
    logic signed [16:0] prev_reg [3];

    logic signed [46:0] prod_reg;
    logic signed [16:0] err_reg;
    logic signed [23:0] acc_reg;
    logic signed [25:0] p_reg;
    logic signed [22:0] i_reg;
    logic signed [31:0] drv_reg [3];
    logic               neg_reg;
    logic [49:0]        quo_reg;
    logic [19:0]        rem_reg;
    logic [5:0]         cnt_reg;

    logic [15:0] kp, ki, kd;
    logic signed [15:0] stick, gyro;
    logic signed [24:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [46:0] mul_p;
    logic signed [17:0] tgt;
    logic signed [18:0] diff_e;
    logic signed [16:0] err_sat;
    logic signed [17:0] diff_d;
    logic signed [46:0] rnd_w;
    logic signed [32:0] inc;
    logic signed [33:0] acc_sum, lim_w;
    logic signed [23:0] acc_clp;
    logic signed [33:0] num;
    logic [33:0]        mag;
    logic [49:0]        dividend;
    logic [20:0]        rem_sh;
    logic               q_bit;
    logic signed [51:0] dval, total;
    logic signed [31:0] drive;

    // per-axis operand selection
    always_comb
    begin
        if (cmd.axis == tarp_pkg::AxisYaw)
        begin
            kp = kp_yaw_reg;
            ki = ki_yaw_reg;
            kd = kd_yaw_reg;
        end
        else
        begin
            kp = kp_rp_reg;
            ki = ki_rp_reg;
            kd = kd_rp_reg;
        end
        case (cmd.axis)
            2'd0:
            begin
                stick = in_reg.stick_roll;
                gyro  = in_reg.rate_x;
            end
            2'd1:
            begin
                stick = in_reg.stick_pitch;
                gyro  = in_reg.rate_y;
            end
            default:
            begin
                stick = in_reg.stick_yaw;
                gyro  = in_reg.rate_z;
            end
        endcase
    end

    // target and saturated error
    always_comb
    begin
        if (cmd.axis == tarp_pkg::AxisYaw)
        begin
            rnd_w = (prod_reg + 47'sd32768) >>> 16;
            tgt   = rnd_w[17:0];
        end
        else
        begin
            rnd_w = 47'(stick) + 47'sd8;
            tgt   = 18'(rnd_w >>> 4);
        end
        diff_e = 19'(tgt) - 19'(gyro);
        if (diff_e > 19'sd65535)
            err_sat = 17'sd65535;
        else if (diff_e < -19'sd65536)
            err_sat = -17'sd65536;
        else
            err_sat = diff_e[16:0];
        diff_d = 18'(err_reg) - 18'(prev_reg[cmd.axis]);
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.op)
            tarp_pkg::OP_TGT:
            begin
                mul_a = 25'(stick);
                mul_b = 22'($signed({6'd0, yaw_scl_reg}));
            end
            tarp_pkg::OP_INC:
            begin
                mul_a = 25'(err_reg);
                mul_b = 22'($signed({2'd0, in_reg.time_step}));
            end
            tarp_pkg::OP_PMUL:
            begin
                mul_a = 25'(err_reg);
                mul_b = 22'($signed({6'd0, kp}));
            end
            tarp_pkg::OP_DMUL:
            begin
                mul_a = 25'(diff_d);
                mul_b = 22'($signed({6'd0, kd}));
            end
            default:
            begin
                mul_a = 25'(acc_reg);
                mul_b = 22'($signed({6'd0, ki}));
            end
        endcase
        mul_p = 47'(mul_a) * 47'(mul_b);
    end

    // integrator update and clamp
    always_comb
    begin
        inc     = 33'((prod_reg + 47'sd8192) >>> 14);
        acc_sum = 34'(integ_reg[cmd.axis]) + 34'(inc);
        lim_w   = $signed({11'd0, int_lim_reg});
        if (acc_sum > lim_w)
            acc_clp = lim_w[23:0];
        else if (acc_sum < -lim_w)
            acc_clp = 24'(-lim_w);
        else
            acc_clp = acc_sum[23:0];
    end

    // divider setup and one restoring step
    always_comb
    begin
        num      = prod_reg[33:0];
        mag      = num[33] ? 34'(-num) : num;
        dividend = {mag[33:0], 16'd0} + 50'(in_reg.time_step >> 1);
        rem_sh   = {rem_reg, quo_reg[49]};
        q_bit    = rem_sh >= {1'b0, in_reg.time_step};
    end

    // final sum and saturation
    always_comb
    begin
        dval  = $signed({2'd0, quo_reg});
        if (neg_reg)
            dval = -dval;
        total = 52'(p_reg) + 52'(i_reg) + dval;
        if (total > 52'sd2147483647)
            drive = 32'h7fff_ffff;
        else if (total < -52'sd2147483648)
            drive = 32'h8000_0000;
        else
            drive = total[31:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_rp_reg   <= 16'd8192;
            ki_rp_reg   <= 16'd4915;
            kd_rp_reg   <= 16'd82;
            kp_yaw_reg  <= 16'd32768;
            ki_yaw_reg  <= 16'd8192;
            kd_yaw_reg  <= 16'd164;
            yaw_scl_reg <= 16'd20480;
            int_lim_reg <= 23'd524288;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tarp_pkg::RegKpRp:   kp_rp_reg   <= cfg_data[15:0];
                tarp_pkg::RegKiRp:   ki_rp_reg   <= cfg_data[15:0];
                tarp_pkg::RegKdRp:   kd_rp_reg   <= cfg_data[15:0];
                tarp_pkg::RegKpYaw:  kp_yaw_reg  <= cfg_data[15:0];
                tarp_pkg::RegKiYaw:  ki_yaw_reg  <= cfg_data[15:0];
                tarp_pkg::RegKdYaw:  kd_yaw_reg  <= cfg_data[15:0];
                tarp_pkg::RegYawScl: yaw_scl_reg <= cfg_data[15:0];
                tarp_pkg::RegIntLim: int_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // loop state and divider counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.op == tarp_pkg::OP_DMUL)
                integ_reg[cmd.axis] <= acc_reg;
            if (cmd.op == tarp_pkg::OP_IMUL)
            begin
                prev_reg[cmd.axis] <= err_reg;
                cnt_reg <= (in_reg.time_step != 20'd0) ? 6'(tarp_pkg::DivBits) : 6'd0;
            end
            else if (cnt_reg != 6'd0)
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == tarp_pkg::OP_LOAD)
            in_reg <= in_req;
        if (cmd.op == tarp_pkg::OP_TGT || cmd.op == tarp_pkg::OP_INC ||
            cmd.op == tarp_pkg::OP_PMUL || cmd.op == tarp_pkg::OP_DMUL ||
            cmd.op == tarp_pkg::OP_IMUL)
            prod_reg <= mul_p;
        if (cmd.op == tarp_pkg::OP_ERR)
            err_reg <= err_sat;
        if (cmd.op == tarp_pkg::OP_PMUL)
            acc_reg <= acc_clp;
        if (cmd.op == tarp_pkg::OP_DMUL)
            p_reg <= 26'((prod_reg + 47'sd128) >>> 8);
        if (cmd.op == tarp_pkg::OP_ILAT)
            i_reg <= 23'((prod_reg + 47'sd131072) >>> 18);
        if (cmd.op == tarp_pkg::OP_IMUL)
        begin
            neg_reg <= num[33];
            quo_reg <= (in_reg.time_step != 20'd0) ? dividend : 50'd0;
            rem_reg <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            quo_reg <= {quo_reg[48:0], q_bit};
            rem_reg <= q_bit ? 20'(rem_sh - {1'b0, in_reg.time_step}) : rem_sh[19:0];
        end
        if (cmd.op == tarp_pkg::OP_SUM)
            drv_reg[cmd.axis] <= drive;
        if (cmd.op == tarp_pkg::OP_OUT)
        begin
            out_reg.roll_drive   <= drv_reg[0];
            out_reg.pitch_drive  <= drv_reg[1];
            out_reg.yaw_drive    <= drv_reg[2];
            out_reg.throttle_out <= in_reg.stick_throttle;
        end
    end

    assign status.div_done = cnt_reg == 6'd0;
    assign out_req         = out_reg;

endmodule

/* hdl/three_axis_rate_pid_unit.sv */
// Three-axis rate PID unit.
// Input channel (in_valid / in_stall / in_req) carries one control tick:
// sticks, throttle, gyro rates and the time step. Output channel
// (out_valid / out_stall / out_req) returns the three Q16.16 drives and
// the throttle copy, one result per tick.
// Gains, yaw scale and integrator limit must be written by the user via
// cfg_we / cfg_index / cfg_data only while the unit is idle (not enforced).
// Each axis runs through one shared 25x22 multiplier (five products) and a
// restoring divider for the derivative, one quotient bit per cycle for a
// 50-bit quotient (skipped when the time step is zero). A new tick can be
// taken in the cycle after the result is loaded; in_stall is high while a
// tick is in work.
// Reset restores the default gains and clears integrators and previous
// errors. A stalled result is held in the output register; the next tick
// may be accepted and worked on meanwhile, and waits before its own load.
`include "three_axis_rate_pid_unit_defines.svh"
module three_axis_rate_pid_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tarp_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output tarp_pkg::out_req_t out_req,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data
);

    tarp_pkg::cmd_t    cmd;
    tarp_pkg::status_t status;
    tarp_pkg::state_t  state;

    tarp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    tarp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (in_req),
        .cmd       (cmd),
        .status    (status),
        .out_req   (out_req)
    );

    `TARP_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    `TARP_ASSERT_NOW(a_div_only_in_div, !status.div_done, state == tarp_pkg::ST_DIV || state == tarp_pkg::ST_ILAT)
    `TARP_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == tarp_pkg::ST_DONE)

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int SettleCycles = 400;
    localparam longint CycleLimit = 1500000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    tarp_pkg::in_req_t   in_req;
    logic                out_valid;
    logic                out_stall;
    tarp_pkg::out_req_t  out_req;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [22:0]         cfg_data;

    three_axis_rate_pid_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_req  (out_req),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor copy of gains and loop state
    longint gain_kp_rp, gain_ki_rp, gain_kd_rp;
    longint gain_kp_y, gain_ki_y, gain_kd_y;
    longint yaw_scale, integ_cap;
    longint integ [3];
    longint prev_err [3];

    tarp_pkg::out_req_t drive_queue [$];
    int   mismatch_count;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    longint cycle_count;

    // directed stimulus rows; has_fixed marks rows whose result is typed in
    typedef struct {
        tarp_pkg::in_req_t  req;
        bit                 has_fixed;
        tarp_pkg::out_req_t fixed;
    } drive_row_t;

    drive_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic reset_gains();
        gain_kp_rp = 8192;
        gain_ki_rp = 4915;
        gain_kd_rp = 82;
        gain_kp_y  = 32768;
        gain_ki_y  = 8192;
        gain_kd_y  = 164;
        yaw_scale  = 20480;
        integ_cap  = 524288;
        for (int a = 0; a < 3; a++)
        begin
            integ[a] = 0;
            prev_err[a] = 0;
        end
    endtask

    // one axis of the PID loop; updates integrator and previous error
    function automatic logic signed [31:0] pid_axis(int a, longint target, longint gyro,
                                                   longint dt, longint kp, longint ki,
                                                   longint kd);
        longint e;
        longint acc;
        longint num;
        longint mag;
        longint q;
        longint d;
        longint p;
        longint i;
        e = clip(target - gyro, -65536, 65535);
        acc = clip(integ[a] + round_shift(e * dt, 14), -integ_cap, integ_cap);
        integ[a] = acc;
        d = 0;
        if (dt != 0)
        begin
            num = kd * (e - prev_err[a]) * 65536;
            mag = (num < 0) ? -num : num;
            q = (mag + dt / 2) / dt;
            d = (num < 0) ? -q : q;
        end
        prev_err[a] = e;
        p = round_shift(kp * e, 8);
        i = round_shift(ki * acc, 18);
        return 32'(clip(p + i + d, -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic tarp_pkg::out_req_t predict_drives(tarp_pkg::in_req_t r);
        tarp_pkg::out_req_t o;
        longint dt;
        longint yt;
        dt = longint'(r.time_step);
        yt = round_shift(longint'(r.stick_yaw) * yaw_scale, 16);
        o.roll_drive  = pid_axis(0, round_shift(longint'(r.stick_roll), 4),
                                 longint'(r.rate_x), dt, gain_kp_rp, gain_ki_rp, gain_kd_rp);
        o.pitch_drive = pid_axis(1, round_shift(longint'(r.stick_pitch), 4),
                                 longint'(r.rate_y), dt, gain_kp_rp, gain_ki_rp, gain_kd_rp);
        o.yaw_drive   = pid_axis(2, yt, longint'(r.rate_z), dt,
                                 gain_kp_y, gain_ki_y, gain_kd_y);
        o.throttle_out = r.stick_throttle;
        return o;
    endfunction

    function automatic void note_register(logic [2:0] idx, logic [22:0] val);
        case (idx)
            tarp_pkg::RegKpRp:   gain_kp_rp = val[15:0];
            tarp_pkg::RegKiRp:   gain_ki_rp = val[15:0];
            tarp_pkg::RegKdRp:   gain_kd_rp = val[15:0];
            tarp_pkg::RegKpYaw:  gain_kp_y  = val[15:0];
            tarp_pkg::RegKiYaw:  gain_ki_y  = val[15:0];
            tarp_pkg::RegKdYaw:  gain_kd_y  = val[15:0];
            tarp_pkg::RegYawScl: yaw_scale  = val[15:0];
            tarp_pkg::RegIntLim: integ_cap  = val;
            default: ;
        endcase
    endfunction

    // one write, then cfg_we is dropped again before the next
    task automatic write_register(logic [2:0] idx, logic [22:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        note_register(idx, val);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // present one request and hold it until accepted
    task automatic send_request(tarp_pkg::in_req_t r);
        while ($urandom_range(99) < sender_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        drive_queue.push_back(predict_drives(r));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tarp_pkg::in_req_t make_req(int sr, int sp, int sy, int th,
                                                   int gx, int gy, int gz, int dt);
        tarp_pkg::in_req_t r;
        r.stick_roll = 16'(sr);
        r.stick_pitch = 16'(sp);
        r.stick_yaw = 16'(sy);
        r.stick_throttle = 15'(th);
        r.rate_x = 16'(gx);
        r.rate_y = 16'(gy);
        r.rate_z = 16'(gz);
        r.time_step = 20'(dt);
        return r;
    endfunction

    function automatic tarp_pkg::in_req_t random_req();
        tarp_pkg::in_req_t r;
        r.stick_roll  = 16'($urandom_range(32768) - 16384);
        r.stick_pitch = 16'($urandom_range(32768) - 16384);
        r.stick_yaw   = 16'($urandom_range(32768) - 16384);
        r.stick_throttle = ($urandom_range(9) == 0) ? 15'h7fff : 15'($urandom_range(16384));
        r.rate_x = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000) - 1000);
        r.rate_y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000) - 1000);
        r.rate_z = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000) - 1000);
        case ($urandom_range(9))
            0:       r.time_step = 20'd0;
            1:       r.time_step = 20'($urandom);
            2:       r.time_step = 20'd1;
            default: r.time_step = 20'($urandom_range(80000, 20000));
        endcase
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            send_request(random_req());
    endtask

    // result checker
    always @(posedge clk)
    begin
        tarp_pkg::out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", out_req);
            end
            else
            begin
                want = drive_queue.pop_front();
                if (out_req.roll_drive !== want.roll_drive
                    || out_req.pitch_drive !== want.pitch_drive
                    || out_req.yaw_drive !== want.yaw_drive
                    || out_req.throttle_out !== want.throttle_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("drive mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.roll_drive, want.pitch_drive, want.yaw_drive,
                                 want.throttle_out, out_req.roll_drive,
                                 out_req.pitch_drive, out_req.yaw_drive,
                                 out_req.throttle_out);
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        tarp_pkg::out_req_t fx;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        sender_idle_pct = 7;
        receiver_idle_pct = 60;
        reset_gains();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero tick after reset gives zero drives
        fx = '0;
        directed_rows.push_back('{make_req(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fx});
        fx.throttle_out = 15'd16384;
        directed_rows.push_back('{make_req(0, 0, 0, 16384, 0, 0, 0, 0), 1'b1, fx});
        directed_rows.push_back('{make_req(16384, -16384, 16384, 100, 0, 0, 0, 40000), 1'b0, fx});
        directed_rows.push_back('{make_req(-16384, 16384, -16384, 0, 0, 0, 0, 1), 1'b0, fx});
        // full-scale gyro rates against opposite sticks, both ways
        directed_rows.push_back('{make_req(16384, -16384, 16384, 7, -32768, 32767, -32768,
                                           1048575), 1'b0, fx});
        directed_rows.push_back('{make_req(-16384, 16384, -16384, 32767, 32767, -32768, 32767,
                                           1048575), 1'b0, fx});
        // zero and small time steps
        directed_rows.push_back('{make_req(1000, -1000, 500, 1, 10, -10, 3, 0), 1'b0, fx});
        directed_rows.push_back('{make_req(-1, 1, -1, 2, 1, -1, 0, 1), 1'b0, fx});
        directed_rows.push_back('{make_req(8, -8, 7, 3, 0, 0, 0, 2), 1'b0, fx});
        for (int k = 0; k < 6; k++)
            directed_rows.push_back('{make_req(16384, 16384, 16384, 9, -32768, -32768, -32768,
                                               1048575), 1'b0, fx});

        foreach (directed_rows[n])
        begin
            send_request(directed_rows[n].req);
            if (directed_rows[n].has_fixed && drive_queue[$] !== directed_rows[n].fixed)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("directed row %0d predicts %h", n, drive_queue[$]);
            end
        end

        // lower the limit: integrators re-clamp on the next tick
        wait_drained();
        write_register(tarp_pkg::RegIntLim, 23'd1000);
        write_register(tarp_pkg::RegIntLim, 23'd1000);
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 100));
        random_phase(150);

        // extremes of all gains
        wait_drained();
        write_register(tarp_pkg::RegKpRp, 23'hffff);
        write_register(tarp_pkg::RegKiRp, 23'hffff);
        write_register(tarp_pkg::RegKdRp, 23'hffff);
        write_register(tarp_pkg::RegKpYaw, 23'hffff);
        write_register(tarp_pkg::RegKiYaw, 23'hffff);
        write_register(tarp_pkg::RegKdYaw, 23'hffff);
        write_register(tarp_pkg::RegYawScl, 23'hffff);
        write_register(tarp_pkg::RegIntLim, 23'h7fffff);
        sender_idle_pct = 60;
        receiver_idle_pct = 7;
        random_phase(150);

        wait_drained();
        write_register(tarp_pkg::RegKpRp, 23'd0);
        write_register(tarp_pkg::RegKiRp, 23'd0);
        write_register(tarp_pkg::RegKdRp, 23'd0);
        write_register(tarp_pkg::RegKpYaw, 23'd0);
        write_register(tarp_pkg::RegKiYaw, 23'd0);
        write_register(tarp_pkg::RegKdYaw, 23'd0);
        write_register(tarp_pkg::RegYawScl, 23'd0);
        write_register(tarp_pkg::RegIntLim, 23'd0);
        random_phase(60);

        // random gains, sender also waits for the queue to empty
        wait_drained();
        write_register(tarp_pkg::RegKpRp, 23'($urandom_range(65535)));
        write_register(tarp_pkg::RegKiRp, 23'($urandom_range(65535)));
        write_register(tarp_pkg::RegKdRp, 23'($urandom_range(2000)));
        write_register(tarp_pkg::RegKpYaw, 23'($urandom_range(65535)));
        write_register(tarp_pkg::RegKiYaw, 23'($urandom_range(65535)));
        write_register(tarp_pkg::RegKdYaw, 23'($urandom_range(2000)));
        write_register(tarp_pkg::RegYawScl, 23'($urandom_range(65535)));
        write_register(tarp_pkg::RegIntLim, 23'($urandom_range(8388607)));
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_phase(100);
        while (drive_queue.size() != 0)
            @(posedge clk);
        random_phase(125);

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
